// ===== design/gla_pkg.sv =====
// Shared constants and codes for the gray levels adjustment block.
`default_nettype none
package gla_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int PIX_W          = 16;
  localparam int PCT_BITS       = 7;
  localparam int GMAX_BITS      = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GMAX  = 2'd2;

  localparam logic [PCT_BITS-1:0]  WHITE_RST = 7'd100;
  localparam logic [PCT_BITS-1:0]  BLACK_RST = 7'd0;
  localparam logic [GMAX_BITS-1:0] GMAX_RST  = 16'd255;

  localparam int KIND_BITS = 2;
  localparam logic [KIND_BITS-1:0] KIND_ZERO = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_DIV  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_MAX  = 2'd2;

endpackage
`default_nettype wire

// ===== design/gla_levels.sv =====
// Two pipeline stages: effective max, percent products, and levels via a shift by two and the reciprocal of 25.
`default_nettype none
module gla_levels #(
  parameter int PIXEL_BITS = gla_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire logic [PIXEL_BITS-1:0]          up_pixel,
  input  wire logic                           up_eoi,
  input  wire logic [gla_pkg::PCT_BITS-1:0]   white_pct,
  input  wire logic [gla_pkg::PCT_BITS-1:0]   black_pct,
  input  wire logic [gla_pkg::GMAX_BITS-1:0]  gray_max,
  output logic                                dn_valid,
  input  wire logic                           dn_ready,
  output logic [PIXEL_BITS-1:0]               dn_pixel,
  output logic                                dn_eoi,
  output logic [PIXEL_BITS-1:0]               dn_maxv,
  output logic [PIXEL_BITS:0]                 dn_white,
  output logic [PIXEL_BITS:0]                 dn_black
);
  import gla_pkg::*;

  localparam int PB    = PIXEL_BITS;
  localparam int PRODB = PB + PCT_BITS;
  localparam int YB    = PRODB - 2;
  localparam int K     = PB + 10;
  localparam int MB    = K - 4;
  localparam logic [MB-1:0] RECIP = MB'((2**K + 24) / 25);
  localparam logic [GMAX_BITS-1:0] PMASK = GMAX_BITS'((2**PB) - 1);

  logic             va_r, vb_r;
  logic             en_a, en_b;
  logic [PB-1:0]    pa_r, pb_r;
  logic             ea_r, eb_r;
  logic [PB-1:0]    ma_r, mb_r;
  logic [PRODB-1:0] prw_r, prb_r;
  logic [PB:0]      lw_r, lb_r;
  logic [PB-1:0]    maxv_nxt;
  logic [YB+MB-1:0] mw, mbk;

  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  always_comb begin
    if (gray_max > PMASK) begin
      maxv_nxt = '1;
    end else begin
      maxv_nxt = gray_max[PB-1:0];
    end
  end

  // floor(x/100) = floor((x>>2)/25), exact for x below 2^(PB+7)
  assign mw  = {{MB{1'b0}}, prw_r[PRODB-1:2]} * {{YB{1'b0}}, RECIP};
  assign mbk = {{MB{1'b0}}, prb_r[PRODB-1:2]} * {{YB{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pa_r  <= up_pixel;
      ea_r  <= up_eoi;
      ma_r  <= maxv_nxt;
      prw_r <= PRODB'(maxv_nxt) * PRODB'(white_pct);
      prb_r <= PRODB'(maxv_nxt) * PRODB'(black_pct);
    end
    if (en_b) begin
      pb_r <= pa_r;
      eb_r <= ea_r;
      mb_r <= ma_r;
      lw_r <= mw[K +: PB+1];
      lb_r <= mbk[K +: PB+1];
    end
  end

  assign dn_valid = vb_r;
  assign dn_pixel = pb_r;
  assign dn_eoi   = eb_r;
  assign dn_maxv  = mb_r;
  assign dn_white = lw_r;
  assign dn_black = lb_r;

endmodule
`default_nettype wire

// ===== design/gla_classify.sv =====
// Classifies a pixel against the levels and forms the division operands.
`default_nettype none
module gla_classify #(
  parameter int PIXEL_BITS = gla_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire logic [PIXEL_BITS-1:0]          up_pixel,
  input  wire logic                           up_eoi,
  input  wire logic [PIXEL_BITS-1:0]          up_maxv,
  input  wire logic [PIXEL_BITS:0]            up_white,
  input  wire logic [PIXEL_BITS:0]            up_black,
  output logic                                dn_valid,
  input  wire logic                           dn_ready,
  output logic [2*PIXEL_BITS-1:0]             dn_num,
  output logic [PIXEL_BITS:0]                 dn_den,
  output logic [gla_pkg::KIND_BITS-1:0]       dn_kind,
  output logic [PIXEL_BITS-1:0]               dn_maxv,
  output logic                                dn_eoi
);
  import gla_pkg::*;

  localparam int PB = PIXEL_BITS;

  logic                 v_r, en;
  logic [2*PB-1:0]      num_r, num_nxt;
  logic [PB:0]          den_r, den_nxt;
  logic [KIND_BITS-1:0] kind_r, kind_nxt;
  logic [PB-1:0]        maxv_r;
  logic                 eoi_r;
  logic [PB:0]          pext, diff;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign pext     = {1'b0, up_pixel};
  assign diff     = pext - up_black;

  always_comb begin
    kind_nxt = KIND_MAX;
    num_nxt  = '0;
    den_nxt  = (PB+1)'(1);
    if (pext <= up_black) begin
      kind_nxt = KIND_ZERO;
    end else if (pext < up_white) begin
      kind_nxt = KIND_DIV;
      num_nxt  = (2*PB)'(diff[PB-1:0]) * (2*PB)'(up_maxv);
      den_nxt  = up_white - up_black;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      kind_r <= kind_nxt;
      maxv_r <= up_maxv;
      eoi_r  <= up_eoi;
    end
  end

  assign dn_valid = v_r;
  assign dn_num   = num_r;
  assign dn_den   = den_r;
  assign dn_kind  = kind_r;
  assign dn_maxv  = maxv_r;
  assign dn_eoi   = eoi_r;

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> den_r != '0)
    else $error("zero divisor in pipeline");

endmodule
`default_nettype wire

// ===== design/gla_div_stage.sv =====
// One restoring division step: produces quotient bit STEP.
`default_nettype none
module gla_div_stage #(
  parameter int PIXEL_BITS = gla_pkg::PIXEL_BITS_DEF,
  parameter int STEP       = 0
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire logic [2*PIXEL_BITS-1:0]        up_rem,
  input  wire logic [PIXEL_BITS:0]            up_den,
  input  wire logic [PIXEL_BITS-1:0]          up_quo,
  input  wire logic [gla_pkg::KIND_BITS-1:0]  up_kind,
  input  wire logic [PIXEL_BITS-1:0]          up_maxv,
  input  wire logic                           up_eoi,
  output logic                                dn_valid,
  input  wire logic                           dn_ready,
  output logic [2*PIXEL_BITS-1:0]             dn_rem,
  output logic [PIXEL_BITS:0]                 dn_den,
  output logic [PIXEL_BITS-1:0]               dn_quo,
  output logic [gla_pkg::KIND_BITS-1:0]       dn_kind,
  output logic [PIXEL_BITS-1:0]               dn_maxv,
  output logic                                dn_eoi
);
  import gla_pkg::*;

  localparam int PB = PIXEL_BITS;
  localparam int RW = 2 * PB;

  logic                 v_r, en;
  logic [RW-1:0]        rem_r, rem_nxt, dsh;
  logic [PB:0]          den_r;
  logic [PB-1:0]        quo_r, quo_nxt;
  logic [KIND_BITS-1:0] kind_r;
  logic [PB-1:0]        maxv_r;
  logic                 eoi_r;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dsh      = RW'(up_den) << STEP;

  always_comb begin
    rem_nxt = up_rem;
    quo_nxt = up_quo;
    if (up_rem >= dsh) begin
      rem_nxt       = up_rem - dsh;
      quo_nxt[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= up_den;
      quo_r  <= quo_nxt;
      kind_r <= up_kind;
      maxv_r <= up_maxv;
      eoi_r  <= up_eoi;
    end
  end

  assign dn_valid = v_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den_r;
  assign dn_quo   = quo_r;
  assign dn_kind  = kind_r;
  assign dn_maxv  = maxv_r;
  assign dn_eoi   = eoi_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && kind_r == KIND_DIV) |-> rem_r < (RW'(den_r) << STEP))
    else $error("partial remainder out of range");

endmodule
`default_nettype wire

// ===== design/gray_levels_adjust.sv =====
// Gray levels adjustment: streams pixels through black/white point level mapping.
//
// Input channel in_valid/in_ready carries one pixel (in_pixel_in) and its
// end-of-image flag; output channel out_valid/out_ready returns the adjusted
// pixel and the same flag, one result per request, in order.
// Configuration (cfg_we, cfg_index, cfg_data) writes white percent (0),
// black percent (1) or gray max (2), one register per write; write only while no
// request is in flight.
// Pipeline: two level stages, one classify stage, one quotient bit per divider
// stage, one output register.
// Throughput is one request per cycle while the receiver takes results, set by the fully pipelined divider.
// Every stage holds its own valid bit; a stalled receiver freezes only the
// occupied stages behind the output register, so bubbles still fill and
// in_ready stays high while any stage is empty.
// Synchronous reset empties the pipeline and restores white 100, black 0,
// gray max 255.
`default_nettype none
module gray_levels_adjust #(
  parameter int PIXEL_BITS = gla_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [gla_pkg::PIX_W-1:0]         in_pixel_in,
  input  wire logic                              in_end_of_image,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [gla_pkg::PIX_W-1:0]              out_pixel_out,
  output logic                                   out_end_of_image_out,
  input  wire logic                              cfg_we,
  input  wire logic [gla_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [gla_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import gla_pkg::*;

  localparam int PB = PIXEL_BITS;
  localparam int RW = 2 * PB;

  logic [PCT_BITS-1:0]  white_r, black_r;
  logic [GMAX_BITS-1:0] gmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r <= WHITE_RST;
      black_r <= BLACK_RST;
      gmax_r  <= GMAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHITE: white_r <= cfg_data[PCT_BITS-1:0];
        CFG_BLACK: black_r <= cfg_data[PCT_BITS-1:0];
        CFG_GMAX:  gmax_r  <= cfg_data[GMAX_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic          lv_valid, lv_ready;
  logic [PB-1:0] lv_pixel, lv_maxv;
  logic          lv_eoi;
  logic [PB:0]   lv_white, lv_black;

  gla_levels #(.PIXEL_BITS(PB)) u_levels (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_pixel  (in_pixel_in[PB-1:0]),
    .up_eoi    (in_end_of_image),
    .white_pct (white_r),
    .black_pct (black_r),
    .gray_max  (gmax_r),
    .dn_valid  (lv_valid),
    .dn_ready  (lv_ready),
    .dn_pixel  (lv_pixel),
    .dn_eoi    (lv_eoi),
    .dn_maxv   (lv_maxv),
    .dn_white  (lv_white),
    .dn_black  (lv_black)
  );

  logic                 dv_w   [PB+1];
  logic                 rdy_w  [PB+1];
  logic [RW-1:0]        rem_w  [PB+1];
  logic [PB:0]          den_w  [PB+1];
  logic [PB-1:0]        quo_w  [PB+1];
  logic [KIND_BITS-1:0] kind_w [PB+1];
  logic [PB-1:0]        maxv_w [PB+1];
  logic                 eoi_w  [PB+1];

  assign quo_w[0] = '0;

  gla_classify #(.PIXEL_BITS(PB)) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lv_valid),
    .up_ready (lv_ready),
    .up_pixel (lv_pixel),
    .up_eoi   (lv_eoi),
    .up_maxv  (lv_maxv),
    .up_white (lv_white),
    .up_black (lv_black),
    .dn_valid (dv_w[0]),
    .dn_ready (rdy_w[0]),
    .dn_num   (rem_w[0]),
    .dn_den   (den_w[0]),
    .dn_kind  (kind_w[0]),
    .dn_maxv  (maxv_w[0]),
    .dn_eoi   (eoi_w[0])
  );

  for (genvar s = 0; s < PB; s++) begin : g_div
    gla_div_stage #(.PIXEL_BITS(PB), .STEP(PB - 1 - s)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_w[s]),
      .up_ready (rdy_w[s]),
      .up_rem   (rem_w[s]),
      .up_den   (den_w[s]),
      .up_quo   (quo_w[s]),
      .up_kind  (kind_w[s]),
      .up_maxv  (maxv_w[s]),
      .up_eoi   (eoi_w[s]),
      .dn_valid (dv_w[s+1]),
      .dn_ready (rdy_w[s+1]),
      .dn_rem   (rem_w[s+1]),
      .dn_den   (den_w[s+1]),
      .dn_quo   (quo_w[s+1]),
      .dn_kind  (kind_w[s+1]),
      .dn_maxv  (maxv_w[s+1]),
      .dn_eoi   (eoi_w[s+1])
    );
  end

  logic          out_valid_r, en_o;
  logic [PB-1:0] res_nxt, res_r;
  logic          eoi_r;

  assign en_o      = !out_valid_r || out_ready;
  assign rdy_w[PB] = en_o;

  always_comb begin
    case (kind_w[PB])
      KIND_ZERO: res_nxt = '0;
      KIND_DIV:  res_nxt = quo_w[PB];
      KIND_MAX:  res_nxt = maxv_w[PB];
      default:   res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= dv_w[PB];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      res_r <= res_nxt;
      eoi_r <= eoi_w[PB];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pixel_out        = PIX_W'(res_r);
  assign out_end_of_image_out = eoi_r;

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output stage");

  a_res_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    dv_w[PB] |-> res_nxt <= maxv_w[PB])
    else $error("result above gray max");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for gray_levels_adjust: level-mapping predictor, scoreboard, random stream.
`default_nettype none
module testbench;
  import gla_pkg::*;

  localparam int PIXEL_BITS = PIXEL_BITS_DEF;
  localparam int LATENCY = PIXEL_BITS + 4;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PCT_FULL = 100;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eoi;
  } gray_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [PIX_W-1:0]         in_pixel_in;
  logic                     in_end_of_image;
  logic                     out_valid;
  logic                     out_ready;
  logic [PIX_W-1:0]         out_pixel_out;
  logic                     out_end_of_image_out;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // mirrored configuration
  logic [PCT_BITS-1:0]  white_pct = WHITE_RST;
  logic [PCT_BITS-1:0]  black_pct = BLACK_RST;
  logic [GMAX_BITS-1:0] gray_top  = GMAX_RST;

  gray_result_t expected_pixels[$];
  int errors = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int settings_used = 0;
  int input_stall_cycles = 0;
  int hold_request = 0;

  gray_levels_adjust #(.PIXEL_BITS(PIXEL_BITS)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_in         (in_pixel_in),
    .in_end_of_image     (in_end_of_image),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_out       (out_pixel_out),
    .out_end_of_image_out(out_end_of_image_out),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("gray_levels_adjust verification failed");
    $finish;
  end

  function automatic logic [23:0] pct_to_level(input logic [PIX_W-1:0] top,
                                               input logic [PCT_BITS-1:0] pct);
    return (24'(top) * 24'(pct)) / 24'(PCT_FULL);
  endfunction

  function automatic logic [PIX_W-1:0] effective_top();
    return (gray_top > GMAX_BITS'(PIX_MASK)) ? PIX_MASK : PIX_W'(gray_top);
  endfunction

  function automatic gray_result_t adjust_pixel(input logic [PIX_W-1:0] pix,
                                                input logic eoi);
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] top;
    logic [23:0]      white_lvl;
    logic [23:0]      black_lvl;
    logic [63:0]      span;
    gray_result_t     r;
    p = pix & PIX_MASK;
    top = effective_top();
    white_lvl = pct_to_level(top, white_pct);
    black_lvl = pct_to_level(top, black_pct);
    if (24'(p) <= black_lvl) begin
      r.pixel = '0;
    end else if (24'(p) < white_lvl) begin
      span = 64'(24'(p) - black_lvl) * 64'(top);
      r.pixel = PIX_W'(span / 64'(white_lvl - black_lvl));
    end else begin
      r.pixel = top;
    end
    r.eoi = eoi;
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  // result checker
  always @(posedge clk) begin
    gray_result_t want;
    if (rst_n && in_valid && !in_ready) input_stall_cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result pixel=%0d eoi=%0b",
                               out_pixel_out, out_end_of_image_out));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_pixel_out !== want.pixel)
          note_failure($sformatf("pixel_out expected %0d got %0d", want.pixel, out_pixel_out));
        if (out_end_of_image_out !== want.eoi)
          note_failure($sformatf("end_of_image_out expected %0b got %0b",
                                 want.eoi, out_end_of_image_out));
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  initial begin
    int mode;
    int left;
    int n;
    mode = 0;
    left = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
      @(posedge clk);
    end
  end

  // valid stays high on return; the next request or a gap decides what follows
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eoi);
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    in_end_of_image <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(adjust_pixel(pix, eoi));
    pixels_sent++;
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_WHITE: white_pct = data[PCT_BITS-1:0];
      CFG_BLACK: black_pct = data[PCT_BITS-1:0];
      CFG_GMAX:  gray_top = data[GMAX_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_levels(input logic [CFG_DATA_BITS-1:0] w,
                            input logic [CFG_DATA_BITS-1:0] b,
                            input logic [CFG_DATA_BITS-1:0] g);
    wait_idle();
    write_reg(CFG_WHITE, w);
    write_reg(CFG_BLACK, b);
    write_reg(CFG_GMAX, g);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [PIX_W-1:0] clamp_pixel(input int v);
    if (v < 0) return '0;
    if (v > int'(PIX_MASK)) return PIX_MASK;
    return PIX_W'(v);
  endfunction

  // pixels one below, at and one above both levels
  task automatic probe_levels();
    int lv[2];
    lv[0] = int'(pct_to_level(effective_top(), black_pct));
    lv[1] = int'(pct_to_level(effective_top(), white_pct));
    foreach (lv[i]) begin
      if (lv[i] > 0) send_pixel(clamp_pixel(lv[i] - 1), 1'b0);
      send_pixel(clamp_pixel(lv[i]), 1'b0);
      send_pixel(clamp_pixel(lv[i] + 1), i == 1);
    end
  endtask

  task automatic test_directed();
    // reset settings: black 0, white 255
    probe_levels();
    send_pixel(16'hFFFF, 1'b1);
    set_levels(16'd80, 16'd20, 16'd255);
    probe_levels();
    // white below black: no linear path
    set_levels(16'd30, 16'd60, 16'd1000);
    probe_levels();
    set_levels(16'd100, 16'd0, 16'd0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    // percent above 100, upper data bits ignored
    set_levels(16'hFF7F, 16'hFF80, 16'hFFFF);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFE, 1'b1);
    wait_idle();
    write_reg(CFG_UNUSED, 16'h0000);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(16'h7FFF, 1'b1);
  endtask

  task automatic test_backpressure();
    set_levels(16'd90, 16'd10, 16'd4095);
    hold_request = 150;
    for (int i = 0; i < 80; i++)
      send_pixel(16'($urandom_range(0, 4095)), i == 79);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 30; i++) send_pixel(16'($urandom), i == 29);
    wait_idle();
    for (int i = 0; i < 30; i++) send_pixel(16'($urandom), i == 29);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    int lvl;
    case ($urandom_range(0, 3))
      0: return PIX_W'($urandom);
      1: return PIX_W'($urandom_range(0, int'(effective_top())));
      2: begin
        lvl = int'(pct_to_level(effective_top(),
                                $urandom_range(0, 1) ? white_pct : black_pct));
        return clamp_pixel(lvl + int'($urandom_range(0, 6)) - 3);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return PIX_MASK;
          default: return effective_top();
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_pct();
    case ($urandom_range(0, 3))
      0: return CFG_DATA_BITS'($urandom);
      1: return CFG_DATA_BITS'($urandom_range(0, 127));
      default: return CFG_DATA_BITS'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_top();
    case ($urandom_range(0, 4))
      0: return CFG_DATA_BITS'($urandom);
      1: return 16'hFFFF;
      2: return CFG_DATA_BITS'($urandom_range(0, 3));
      default: return CFG_DATA_BITS'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic test_random_stream();
    logic [CFG_DATA_BITS-1:0] corner_w[6] = '{16'd0, 16'd127, 16'd100, 16'd0, 16'd127, 16'd50};
    logic [CFG_DATA_BITS-1:0] corner_b[6] = '{16'd0, 16'd127, 16'd0, 16'd100, 16'd0, 16'd50};
    logic [CFG_DATA_BITS-1:0] corner_g[6] = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd255, 16'd1, 16'd0};
    int burst;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase < 6) set_levels(corner_w[phase], corner_b[phase], corner_g[phase]);
      else set_levels(pick_pct(), pick_pct(), pick_top());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
      end
      for (int n = 0; n < 50; n += burst) begin
        burst = $urandom_range(1, 30);
        for (int k = 0; k < burst; k++)
          send_pixel(pick_pixel(), $urandom_range(0, 15) == 0);
        sender_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_in = '0;
    in_end_of_image = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random_stream();
    wait_idle();
    $display("%0d pixels sent and %0d checked across %0d level settings",
             pixels_sent, pixels_checked, settings_used);
    $display("input held off for %0d cycles under output stalls", input_stall_cycles);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("gray_levels_adjust verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_pixels.size());
      $display("gray_levels_adjust verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/gla_pkg.sv
design/gla_levels.sv
design/gla_classify.sv
design/gla_div_stage.sv
design/gray_levels_adjust.sv
dv/testbench.sv
